// ----- hdl/mmda_pkg.sv -----
// ----------------------------------------------------------------------------
// mmda_pkg
// shared types and constants of the min-max distance accumulator
// ----------------------------------------------------------------------------
package mmda_pkg;

  localparam int VAL_W    = 16;
  localparam int MAG_W    = 17;
  localparam int SUM_W    = 32;
  localparam int DIST_W   = 17;
  localparam int FRAC_W   = 16;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [DIST_W-1:0] ONE_Q16 = DIST_W'(1) << FRAC_W;
  localparam logic [SUM_W-1:0]  SUM_MAX = '1;

  // register index of the threshold in the configuration space
  localparam logic REG_THRESHOLD = 1'b0;

  // queue of finished sums between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one quotient bit per divider step
  localparam int DIV_STEPS = DIST_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [SUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } sum_pair_t;

  typedef struct packed {
    logic      valid;
    sum_pair_t data;
  } queue_beat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

// ----- hdl/mmda_front.sv -----
// ----------------------------------------------------------------------------
// mmda_front
// accepts element pairs, classifies them by sign and accumulates the sums
// ----------------------------------------------------------------------------
module mmda_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mmda_pkg::VAL_W-1:0]   in_value_a,
  input  logic signed [mmda_pkg::VAL_W-1:0]   in_value_b,
  input  logic                                in_last,
  input  logic                                q_full,
  output mmda_pkg::queue_beat_t               push
);
  import mmda_pkg::*;

  logic [SUM_W-1:0] num_r, num_nxt;
  logic [SUM_W-1:0] den_r, den_nxt;
  logic [MAG_W-1:0] mag_a, mag_b, lo, hi, add_num, add_den;
  logic             pos_a, pos_b, neg_a, neg_b, same_sign, accept;
  logic [SUM_W:0]   sum_num, sum_den;
  logic [SUM_W-1:0] sat_num, sat_den;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign mag_a = in_value_a[VAL_W-1] ? MAG_W'(-$signed({in_value_a[VAL_W-1], in_value_a}))
                                     : MAG_W'(in_value_a);
  assign mag_b = in_value_b[VAL_W-1] ? MAG_W'(-$signed({in_value_b[VAL_W-1], in_value_b}))
                                     : MAG_W'(in_value_b);

  assign neg_a = in_value_a[VAL_W-1];
  assign neg_b = in_value_b[VAL_W-1];
  assign pos_a = !neg_a && (in_value_a != '0);
  assign pos_b = !neg_b && (in_value_b != '0);
  assign same_sign = (pos_a && pos_b) || (neg_a && neg_b);

  assign lo = (mag_a < mag_b) ? mag_a : mag_b;
  assign hi = (mag_a < mag_b) ? mag_b : mag_a;

  // same sign: lo to num, hi to den; mixed signs or a zero: both to den
  always_comb begin
    if (same_sign) begin
      add_num = lo;
      add_den = hi;
    end else begin
      add_num = '0;
      add_den = mag_a + mag_b;
    end
  end

  assign sum_num = {1'b0, num_r} + (SUM_W+1)'(add_num);
  assign sum_den = {1'b0, den_r} + (SUM_W+1)'(add_den);
  assign sat_num = sum_num[SUM_W] ? SUM_MAX : sum_num[SUM_W-1:0];
  assign sat_den = sum_den[SUM_W] ? SUM_MAX : sum_den[SUM_W-1:0];

  always_comb begin
    num_nxt = num_r;
    den_nxt = den_r;
    push.valid    = 1'b0;
    push.data.num = sat_num;
    push.data.den = sat_den;
    if (accept) begin
      if (in_last) begin
        push.valid = 1'b1;
        num_nxt    = '0;
        den_nxt    = '0;
      end else begin
        num_nxt = sat_num;
        den_nxt = sat_den;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= '0;
      den_r <= '0;
    end else begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

endmodule

// ----- hdl/mmda_queue.sv -----
// ----------------------------------------------------------------------------
// mmda_queue
// short queue of finished sum pairs between accumulator and divider
// ----------------------------------------------------------------------------
module mmda_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mmda_pkg::queue_beat_t push,
  output logic                  full,
  output mmda_pkg::queue_beat_t head,
  input  logic                  pop
);
  import mmda_pkg::*;

  sum_pair_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.data  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !do_push)
    else $error("queue written while full");
`endif

endmodule

// ----- hdl/mmda_back.sv -----
// ----------------------------------------------------------------------------
// mmda_back
// bit-serial divider for the distance and the result output register
// ----------------------------------------------------------------------------
module mmda_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mmda_pkg::queue_beat_t         head,
  output logic                          pop,
  input  logic [mmda_pkg::DIST_W-1:0]   threshold,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mmda_pkg::DIST_W-1:0]   out_distance,
  output logic                          out_within_res,
  output logic                          out_zero_denominator
);
  import mmda_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [SUM_W:0]    rem_r, rem_nxt;
  logic [SUM_W-1:0]  div_r, div_nxt;
  logic [DIST_W-1:0] quot_r, quot_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              zero_r, zero_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] dist_r;
  logic              within_r, zden_r;
  logic              load_out;
  logic [SUM_W:0]    trial;
  logic              ge;
  logic [SUM_W-1:0]  num_clip;

  assign num_clip = (head.data.num > head.data.den) ? head.data.den : head.data.num;

  // the first step takes the remainder as is, later ones shift in a zero
  assign trial = (cnt_r == '0) ? rem_r : {rem_r[SUM_W-1:0], 1'b0};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    quot_nxt  = quot_r;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    pop       = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.data.den == '0) begin
            quot_nxt  = ONE_Q16;
            zero_nxt  = 1'b1;
            state_nxt = B_DONE;
          end else begin
            rem_nxt   = {1'b0, head.data.den - num_clip};
            div_nxt   = head.data.den;
            quot_nxt  = '0;
            cnt_nxt   = '0;
            zero_nxt  = 1'b0;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        rem_nxt  = ge ? (trial - {1'b0, div_r}) : trial;
        quot_nxt = {quot_r[DIST_W-2:0], ge};
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = B_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      B_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
    if (load_out) begin
      dist_r   <= quot_r;
      within_r <= !zero_r && (quot_r <= threshold);
      zden_r   <= zero_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_distance         = dist_r;
  assign out_within_res       = within_r;
  assign out_zero_denominator = zden_r;

`ifndef SYNTH
  a_zero_den_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_denominator |-> out_distance == ONE_Q16 && !out_within_res)
    else $error("zero denominator result malformed");
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance <= ONE_Q16)
    else $error("distance above one");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != B_IDLE |-> !pop)
    else $error("queue popped while divider busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DIV && cnt_r != '0 |-> rem_r < {1'b0, div_r})
    else $error("divider remainder out of range");
`endif

endmodule

// ----- hdl/minmax_distance_accumulator.sv -----
// ----------------------------------------------------------------------------
// minmax_distance_accumulator
// streaming generalized min-max distance of two signed Q7.8 vectors
// ----------------------------------------------------------------------------
// Element pairs are taken at one beat per clock while in_stall is low. Each
// vector's sums are handed to a two-entry queue on its last beat, and a
// bit-serial divider then pops them, works out the quotient one bit per
// step and loads the output register with the result. in_stall rises only
// while the queue holds two finished vectors, which happens when short
// vectors arrive back to back faster than the divider finishes them. Sums
// saturate at 0xFFFFFFFF. A vector whose denominator is zero gives distance
// 65536 (1.0), within_res 0 and zero_denominator 1. The threshold register
// lives at byte address 0 and resets to 65536.
// ----------------------------------------------------------------------------
module minmax_distance_accumulator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input element pairs
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mmda_pkg::VAL_W-1:0]    in_value_a,
  input  logic signed [mmda_pkg::VAL_W-1:0]    in_value_b,
  input  logic                                 in_last,
  // results
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mmda_pkg::DIST_W-1:0]          out_distance,
  output logic                                 out_within_res,
  output logic                                 out_zero_denominator,
  // configuration
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [mmda_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [mmda_pkg::CFG_DW-1:0]          cfg_pwdata,
  output logic [mmda_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                 cfg_pready
);
  import mmda_pkg::*;

  logic [DIST_W-1:0] thr_r, thr_nxt;
  logic              cfg_wr;
  logic              q_full, q_pop;
  queue_beat_t       push, head;

  // register select is the word index; byte lanes below it are ignored
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_wr && (cfg_paddr[CFG_AW-1] == REG_THRESHOLD)) begin
      thr_nxt = cfg_pwdata[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ONE_Q16;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  // read back: only the threshold exists, other words read as zero
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_THRESHOLD) ? CFG_DW'(thr_r) : '0;

  // front: sign classification and saturating sums
  mmda_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value_a (in_value_a),
    .in_value_b (in_value_b),
    .in_last    (in_last),
    .q_full     (q_full),
    .push       (push)
  );

  // finished vectors wait here while the divider works
  mmda_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (q_pop)
  );

  // back: divider, threshold compare and output register
  mmda_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .pop                  (q_pop),
    .threshold            (thr_r),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_distance         (out_distance),
    .out_within_res       (out_within_res),
    .out_zero_denominator (out_zero_denominator)
  );

endmodule

// ----- verif/minmax_distance_accumulator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// minmax_distance_accumulator_test
// self-checking bench for the streaming min-max distance accumulator
// ----------------------------------------------------------------------------
// Pairs of Q7.8 elements are fed over the valid/stall input channel. A
// shadow accumulator folds every accepted pair into its own sums and, on
// each closing pair, queues the distance, the within flag and the
// zero-denominator flag that the block must return. Results are popped in
// order and compared field by field. The run is a short table of hand-picked
// pairs followed by random vectors under several threshold settings and
// idle/stall mixes.
// ----------------------------------------------------------------------------
module minmax_distance_accumulator_test;
  import mmda_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 5;
  // let the divider finish, with a wide margin before touching config
  localparam int SETTLE_CYCLES = 40;
  localparam int RUN_LIMIT_NS  = 10_000_000;
  localparam int PHASE_ITEMS   = 100;
  localparam int NUM_PHASES    = 5;
  localparam logic [CFG_AW-1:0] THRESHOLD_ADDR = CFG_AW'(4 * REG_THRESHOLD);

  // one result beat as the block presents it
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              within_res;
    logic              zero_denominator;
  } dist_beat_t;

  // one row of the hand-written stimulus table
  typedef struct {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic                    last;
    logic                    typed;
    dist_beat_t              want;
  } pair_row_t;

  localparam int N_DIRECTED = 22;

  // threshold is still at its reset value of 1.0 while this table runs
  pair_row_t directed_rows [N_DIRECTED] = '{
    // all-zero vector right after reset: zero denominator
    '{0, 0, 1, 1, '{ONE_Q16, 1'b0, 1'b1}},
    // identical positive elements: distance zero
    '{256, 256, 1, 1, '{'0, 1'b1, 1'b0}},
    // opposite signs only: distance 1.0, still within a 1.0 threshold
    '{256, -256, 1, 1, '{ONE_Q16, 1'b1, 1'b0}},
    // full-scale extremes
    '{32767, 32767, 1, 1, '{'0, 1'b1, 1'b0}},
    '{-32768, -32768, 1, 1, '{'0, 1'b1, 1'b0}},
    '{-32768, 32767, 1, 1, '{ONE_Q16, 1'b1, 1'b0}},
    // a zero element falls into the mixed-sign branch
    '{0, -32768, 1, 1, '{ONE_Q16, 1'b1, 1'b0}},
    // multi-pair vector of zeros
    '{0, 0, 0, 0, '0},
    '{0, 0, 1, 1, '{ONE_Q16, 1'b0, 1'b1}},
    // mixed vectors, checked against the shadow accumulator
    '{512, 256, 0, 0, '0},
    '{-256, -768, 1, 0, '0},
    '{1, 0, 0, 0, '0},
    '{-1, -1, 1, 0, '0},
    '{32767, -1, 0, 0, '0},
    '{3, 5, 0, 0, '0},
    '{-7, -2, 1, 0, '0},
    '{1, 1, 0, 0, '0},
    '{0, 0, 0, 0, '0},
    '{0, 0, 1, 0, '0},
    '{-1, 1, 1, 0, '0},
    '{1, 32767, 1, 0, '0},
    '{-32768, -1, 1, 0, '0}
  };

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_value_a = '0;
  logic signed [VAL_W-1:0] in_value_b = '0;
  logic                    in_last = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [DIST_W-1:0]       out_distance;
  logic                    out_within_res;
  logic                    out_zero_denominator;
  logic                    cfg_psel = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]       cfg_paddr = '0;
  logic [CFG_DW-1:0]       cfg_pwdata = '0;
  logic [CFG_DW-1:0]       cfg_prdata;
  logic                    cfg_pready;

  // shadow copy of the block's sums and threshold
  logic [SUM_W-1:0]  num_acc = '0;
  logic [SUM_W-1:0]  den_acc = '0;
  logic [DIST_W-1:0] threshold_shadow = ONE_Q16;

  // distances still owed by the block, oldest first
  dist_beat_t awaited_distances[$];
  int         mismatch_count = 0;

  // idle and stall odds, in percent
  int send_idle_pct = 0;
  int stall_pct = 0;

  minmax_distance_accumulator DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_value_a           (in_value_a),
    .in_value_b           (in_value_b),
    .in_last              (in_last),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_distance         (out_distance),
    .out_within_res       (out_within_res),
    .out_zero_denominator (out_zero_denominator),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow accumulator
  // ---------------------------------------------------------------------------

  function automatic logic [MAG_W-1:0] magnitude(input logic signed [VAL_W-1:0] v);
    logic signed [MAG_W-1:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  // sums stick at all-ones instead of wrapping
  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] s,
                                              input logic [MAG_W:0]   x);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W + 1)'(x);
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  // fold one pair into the sums; on a closing pair return the distance beat
  function automatic bit accumulate_pair(input logic signed [VAL_W-1:0] a,
                                         input logic signed [VAL_W-1:0] b,
                                         input logic                    last_flag,
                                         output dist_beat_t             r);
    logic [MAG_W-1:0]        ma;
    logic [MAG_W-1:0]        mb;
    logic [SUM_W-1:0]        num_c;
    logic [SUM_W+FRAC_W-1:0] quot;
    ma = magnitude(a);
    mb = magnitude(b);
    r = '0;
    if ((a > 0 && b > 0) || (a < 0 && b < 0)) begin
      // same sign: smaller magnitude to the numerator, larger to the denominator
      num_acc = sat_sum(num_acc, {1'b0, (ma < mb) ? ma : mb});
      den_acc = sat_sum(den_acc, {1'b0, (ma < mb) ? mb : ma});
    end else begin
      den_acc = sat_sum(den_acc, {1'b0, ma} + {1'b0, mb});
    end
    if (!last_flag) return 1'b0;
    if (den_acc == '0) begin
      r.distance = ONE_Q16;
      r.within_res = 1'b0;
      r.zero_denominator = 1'b1;
    end else begin
      num_c = (num_acc > den_acc) ? den_acc : num_acc;
      quot = {den_acc - num_c, {FRAC_W{1'b0}}} / (SUM_W + FRAC_W)'(den_acc);
      r.distance = quot[DIST_W-1:0];
      r.within_res = (r.distance <= threshold_shadow);
      r.zero_denominator = 1'b0;
    end
    num_acc = '0;
    den_acc = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // input side, entered and left at a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_pair(input logic signed [VAL_W-1:0] a,
                           input logic signed [VAL_W-1:0] b,
                           input logic                    last_flag);
    // random gaps in front of the beat
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_value_a <= a;
    in_value_b <= b;
    in_last    <= last_flag;
    // payload holds until the beat is taken
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // predict, queue the expected beat, then send; a typed row overrides the prediction
  task automatic feed_pair(input logic signed [VAL_W-1:0] a,
                           input logic signed [VAL_W-1:0] b,
                           input logic                    last_flag,
                           input logic                    typed = 1'b0,
                           input dist_beat_t              want = '0);
    dist_beat_t predicted;
    if (accumulate_pair(a, b, last_flag, predicted))
      awaited_distances.insert(awaited_distances.size(), typed ? want : predicted);
    send_pair(a, b, last_flag);
  endtask

  // drop valid, let every owed result come out, then give the divider time
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_distances.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // threshold register: write with junk above bit 16, then read it back
  // ---------------------------------------------------------------------------

  task automatic write_threshold(input logic [DIST_W-1:0] value);
    logic [CFG_DW-1:0] junk;
    junk = $urandom();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= THRESHOLD_ADDR;
    cfg_pwdata  <= {junk[CFG_DW-1:DIST_W], value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    threshold_shadow = value;
    @(negedge clk);
    // read phase reuses the same select
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(value)) begin
      $error("threshold readback: expected %0d, got %0d", value, cfg_prdata);
      mismatch_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // random vectors
  // ---------------------------------------------------------------------------

  function automatic logic signed [VAL_W-1:0] random_element();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2, 3: return VAL_W'($urandom_range(0, 600)) - 16'sd300;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  task automatic run_random_vectors(input int n_pairs);
    int                      sent;
    int                      len;
    bit                      zero_vec;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    sent = 0;
    while (sent < n_pairs) begin
      // mostly short vectors so the result queue fills and in_stall shows up
      case ($urandom_range(0, 19))
        0: len = $urandom_range(31, 80);
        1, 2, 3, 4, 5: len = $urandom_range(7, 30);
        default: len = $urandom_range(1, 6);
      endcase
      zero_vec = ($urandom_range(0, 19) == 0);
      for (int i = 0; i < len; i++) begin
        a = zero_vec ? '0 : random_element();
        b = zero_vec ? '0 : random_element();
        // lean toward matching signs so the numerator sum gets exercised
        if (!zero_vec && $urandom_range(0, 1)) b[VAL_W-1] = a[VAL_W-1];
        feed_pair(a, b, i == len - 1);
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  always @(negedge clk)
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    dist_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_distances.size() == 0) begin
        $error("result beat with nothing expected: distance %0d", out_distance);
        mismatch_count++;
      end else begin
        want = awaited_distances.pop_front();
        if (out_distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, out_distance);
          mismatch_count++;
        end
        if (out_within_res !== want.within_res) begin
          $error("within_res: expected %0d, got %0d", want.within_res, out_within_res);
          mismatch_count++;
        end
        if (out_zero_denominator !== want.zero_denominator) begin
          $error("zero_denominator: expected %0d, got %0d",
                 want.zero_denominator, out_zero_denominator);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------

  initial begin
    int                phase_idle [NUM_PHASES] = '{0, 58, 0, 30, 0};
    int                phase_stall [NUM_PHASES] = '{0, 0, 58, 30, 0};
    logic [DIST_W-1:0] phase_thr [NUM_PHASES] = '{'0, '1, '0, ONE_Q16, 17'd32768};
    logic [DIST_W-1:0] thr;

    // synchronous reset, released after the RESET_CYCLES wait
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // hand-picked pairs at the reset threshold
    foreach (directed_rows[i])
      feed_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // random vectors under each threshold and idle/stall mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      thr = (p == 2) ? DIST_W'($urandom_range(1, 65535)) : phase_thr[p];
      write_threshold(thr);
      send_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      run_random_vectors(PHASE_ITEMS);
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mmda_pkg.sv
hdl/mmda_front.sv
hdl/mmda_queue.sv
hdl/mmda_back.sv
hdl/minmax_distance_accumulator.sv
verif/minmax_distance_accumulator_test.sv
